FILE: hdl/alloc_site_stats_table_core_assert.svh
// Assertion macros used by the checker of the site statistics table.
`ifndef ALLOC_SITE_STATS_TABLE_CORE_ASSERT_SVH
`define ALLOC_SITE_STATS_TABLE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ASTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("site stats table check failed");

// antecedent implies consequent in the next cycle
`define ASTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("site stats table check failed");

`endif

FILE: hdl/astc_pkg.sv
// Types, constants, hash step function and saturating helpers of the site statistics table.
`timescale 1ns / 1ps
package astc_pkg;

    localparam int TABLE_SIZE = 4096;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int SLOT_W     = 13;
    localparam logic [SLOT_W-1:0] SLOT_OVF  = SLOT_W'(TABLE_SIZE);
    localparam logic [SLOT_W-1:0] HALF_USED = SLOT_W'(TABLE_SIZE / 2);
    localparam logic [31:0] GOLDEN = 32'h9e3779b9;
    localparam logic [3:0]  MIX_LAST = 4'd8;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;

    localparam logic [2:0] OC_HIT  = 3'd0;
    localparam logic [2:0] OC_NEW  = 3'd1;
    localparam logic [2:0] OC_OVF  = 3'd2;
    localparam logic [2:0] OC_SKIP = 3'd3;
    localparam logic [2:0] OC_READ = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] address;
        logic [31:0] line;
        logic [47:0] total_bytes;
        logic [31:0] total_allocs;
        logic [47:0] live_bytes;
        logic [31:0] live_allocs;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } hash_t;

    // one line of the lookup2 mix
    function automatic hash_t mix_step(hash_t h, logic [3:0] k);
        hash_t r;
        r = h;
        case (k)
            4'd0: begin r.a = h.a - h.b - h.c; r.a = r.a ^ (h.c >> 13); end
            4'd1: begin r.b = h.b - h.c - h.a; r.b = r.b ^ (h.a << 8);  end
            4'd2: begin r.c = h.c - h.a - h.b; r.c = r.c ^ (h.b >> 13); end
            4'd3: begin r.a = h.a - h.b - h.c; r.a = r.a ^ (h.c >> 12); end
            4'd4: begin r.b = h.b - h.c - h.a; r.b = r.b ^ (h.a << 16); end
            4'd5: begin r.c = h.c - h.a - h.b; r.c = r.c ^ (h.b >> 5);  end
            4'd6: begin r.a = h.a - h.b - h.c; r.a = r.a ^ (h.c >> 3);  end
            4'd7: begin r.b = h.b - h.c - h.a; r.b = r.b ^ (h.a << 10); end
            4'd8: begin r.c = h.c - h.a - h.b; r.c = r.c ^ (h.b >> 15); end
            default: r = h;
        endcase
        return r;
    endfunction

    function automatic logic [47:0] sat_add48(logic [47:0] x, logic [47:0] y);
        logic [48:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function automatic logic [31:0] sat_inc32(logic [31:0] x);
        return (&x) ? x : x + 32'd1;
    endfunction

endpackage

FILE: hdl/astc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module astc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/alloc_site_stats_table_core.sv
// Top level of the allocation site statistics table.
//
//  channel | handshake             | word
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_ready   | operation, site_address, site_line,
//          |                       | alloc_size, read_slot
//  out     | out_valid / out_ready | slot, outcome, entry_*, totals, live, used
//
// After reset the table RAM is swept to zero, one slot a cycle, with
// in_ready low.
// Alloc/free: accept, hash (two lookup2 passes of 9 mix lines; one pass when
// line is 0), a read and a check state per probed slot, then update.
// Read: accept, RAM read, update.
// Probing is serial on the single RAM read port; the result register lets
// a new word be accepted while the previous result waits on out_ready.
`timescale 1ns / 1ps
module alloc_site_stats_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     operation,
    input  logic [63:0]                    site_address,
    input  logic [31:0]                    site_line,
    input  logic [47:0]                    alloc_size,
    input  logic [12:0]                    read_slot,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [12:0]                    slot,
    output logic [2:0]                     outcome,
    output logic                           entry_valid,
    output logic [63:0]                    entry_address,
    output logic [31:0]                    entry_line,
    output logic [47:0]                    total_bytes,
    output logic [31:0]                    total_allocs,
    output logic [47:0]                    live_bytes,
    output logic [31:0]                    live_allocs,
    output logic [12:0]                    sites_used
);

    localparam int IW = astc_pkg::IDX_W;

    astc_pkg::state_t state_reg, state_next;

    // request word
    logic [1:0]  op_reg, op_next;
    logic [63:0] addr_reg, addr_next;
    logic [31:0] line_reg, line_next;
    logic [47:0] size_reg, size_next;

    // hash unit
    astc_pkg::hash_t h_reg, h_next, h_mixed;
    logic [3:0]  step_reg, step_next;
    logic        pass2_reg, pass2_next;

    // probe walk
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] clr_reg, clr_next;

    // overflow entry and fill count
    logic [47:0] otb_reg, otb_next, olb_reg, olb_next;
    logic [31:0] otc_reg, otc_next, olc_reg, olc_next;
    logic [12:0] used_reg, used_next;

    // result register
    logic        ov_reg, ov_next;
    logic [12:0] r_slot_reg, r_slot_next;
    logic [2:0]  r_oc_reg, r_oc_next;
    astc_pkg::entry_t r_e_reg, r_e_next;
    logic [12:0] r_used_reg, r_used_next;

    // RAM port
    logic                       ram_we, ram_re;
    logic [IW-1:0]              ram_waddr, ram_raddr;
    logic [astc_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    astc_pkg::entry_t           e_rd, e_new;

    logic in_go, upd_go, hit, probe_last;

    astc_ram #(
        .WIDTH (astc_pkg::ENTRY_W),
        .DEPTH (astc_pkg::TABLE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign e_rd       = astc_pkg::entry_t'(ram_rdata);
    assign h_mixed    = astc_pkg::mix_step(h_reg, step_reg);
    assign in_go      = in_valid && in_ready;
    // result register free to take this update
    assign upd_go     = (state_reg == astc_pkg::ST_UPDATE) && (!ov_reg || out_ready);
    assign hit        = !e_rd.valid || (e_rd.address == addr_reg && e_rd.line == line_reg);
    assign probe_last = (cnt_reg == IW'(astc_pkg::TABLE_SIZE - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            astc_pkg::ST_CLEAR:
                if (clr_reg == IW'(astc_pkg::TABLE_SIZE - 1))
                    state_next = astc_pkg::ST_IDLE;
            astc_pkg::ST_IDLE:
                if (in_go)
                    state_next = (operation == astc_pkg::OP_ALLOC ||
                                  operation == astc_pkg::OP_FREE)
                                 ? astc_pkg::ST_HASH : astc_pkg::ST_PROBE_RD;
            astc_pkg::ST_HASH:
                if (step_reg == astc_pkg::MIX_LAST && (pass2_reg || line_reg == 32'd0))
                    state_next = astc_pkg::ST_PROBE_RD;
            astc_pkg::ST_PROBE_RD:
                state_next = (op_reg == astc_pkg::OP_ALLOC || op_reg == astc_pkg::OP_FREE)
                             ? astc_pkg::ST_PROBE_CHK : astc_pkg::ST_UPDATE;
            astc_pkg::ST_PROBE_CHK:
                state_next = (hit || probe_last) ? astc_pkg::ST_UPDATE
                                                 : astc_pkg::ST_PROBE_RD;
            astc_pkg::ST_UPDATE:
                if (upd_go)
                    state_next = astc_pkg::ST_IDLE;
            default:
                state_next = astc_pkg::ST_IDLE;
        endcase
    end

    // state outputs: handshake and RAM read
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        case (state_reg)
            astc_pkg::ST_IDLE:     in_ready = 1'b1;
            astc_pkg::ST_PROBE_RD: ram_re   = 1'b1;
            default:               ;
        endcase
    end

    // datapath
    always_comb
    begin
        logic        eff_ovf;
        logic [2:0]  oc;
        logic [47:0] btb, blb;
        logic [31:0] btc, blc;

        op_next     = op_reg;
        addr_next   = addr_reg;
        line_next   = line_reg;
        size_next   = size_reg;
        h_next      = h_reg;
        step_next   = step_reg;
        pass2_next  = pass2_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        clr_next    = clr_reg;
        otb_next    = otb_reg;
        otc_next    = otc_reg;
        olb_next    = olb_reg;
        olc_next    = olc_reg;
        used_next   = used_reg;
        ov_next     = ov_reg && !out_ready;
        r_slot_next = r_slot_reg;
        r_oc_next   = r_oc_reg;
        r_e_next    = r_e_reg;
        r_used_next = r_used_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        e_new       = e_rd;
        eff_ovf     = ovf_reg;
        oc          = astc_pkg::OC_READ;
        btb         = otb_reg;
        btc         = otc_reg;
        blb         = olb_reg;
        blc         = olc_reg;

        case (state_reg)
            astc_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                e_new     = '0;
                clr_next  = clr_reg + IW'(1);
            end
            astc_pkg::ST_IDLE:
            begin
                op_next    = operation;
                addr_next  = site_address;
                line_next  = site_line;
                size_next  = alloc_size;
                // first lookup2 pass over the 8 address bytes
                h_next.a   = astc_pkg::GOLDEN + site_address[31:0];
                h_next.b   = astc_pkg::GOLDEN + site_address[63:32];
                h_next.c   = 32'd8;
                step_next  = 4'd0;
                pass2_next = 1'b0;
                cnt_next   = '0;
                ovf_next   = (read_slot >= astc_pkg::SLOT_OVF);
                idx_next   = read_slot[IW-1:0];
            end
            astc_pkg::ST_HASH:
            begin
                h_next    = h_mixed;
                step_next = step_reg + 4'd1;
                if (step_reg == astc_pkg::MIX_LAST)
                begin
                    step_next = 4'd0;
                    if (!pass2_reg && line_reg != 32'd0)
                    begin
                        // second pass over the 4 line bytes, seeded by the first
                        pass2_next = 1'b1;
                        h_next.a   = astc_pkg::GOLDEN + line_reg;
                        h_next.b   = astc_pkg::GOLDEN;
                        h_next.c   = h_mixed.c + 32'd4;
                    end
                    else
                    begin
                        ovf_next = 1'b0;
                        idx_next = (line_reg == 32'd0 && addr_reg == 64'd0)
                                   ? '0 : h_mixed.c[IW-1:0];
                    end
                end
            end
            astc_pkg::ST_PROBE_CHK:
            begin
                if (!hit)
                begin
                    if (probe_last)
                        ovf_next = 1'b1;
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
            end
            astc_pkg::ST_UPDATE:
            begin
                case (op_reg)
                    astc_pkg::OP_ALLOC:
                    begin
                        if (!ovf_reg && !e_rd.valid)
                        begin
                            if (used_reg > astc_pkg::HALF_USED)
                            begin
                                eff_ovf = 1'b1;
                                oc      = astc_pkg::OC_OVF;
                            end
                            else
                            begin
                                oc            = astc_pkg::OC_NEW;
                                e_new.valid   = 1'b1;
                                e_new.address = addr_reg;
                                e_new.line    = line_reg;
                            end
                        end
                        else
                            oc = ovf_reg ? astc_pkg::OC_OVF : astc_pkg::OC_HIT;
                    end
                    astc_pkg::OP_FREE:
                    begin
                        eff_ovf = ovf_reg || !e_rd.valid;
                        oc      = eff_ovf ? astc_pkg::OC_OVF : astc_pkg::OC_HIT;
                    end
                    default:
                        oc = astc_pkg::OC_READ;
                endcase

                btb = eff_ovf ? otb_reg : e_rd.total_bytes;
                btc = eff_ovf ? otc_reg : e_rd.total_allocs;
                blb = eff_ovf ? olb_reg : e_rd.live_bytes;
                blc = eff_ovf ? olc_reg : e_rd.live_allocs;

                case (op_reg)
                    astc_pkg::OP_ALLOC:
                    begin
                        btb = astc_pkg::sat_add48(btb, size_reg);
                        btc = astc_pkg::sat_inc32(btc);
                        blb = astc_pkg::sat_add48(blb, size_reg);
                        blc = astc_pkg::sat_inc32(blc);
                    end
                    astc_pkg::OP_FREE:
                    begin
                        if (blb >= size_reg && blc != 32'd0)
                        begin
                            blb = blb - size_reg;
                            blc = blc - 32'd1;
                        end
                        else
                            oc = astc_pkg::OC_SKIP;
                    end
                    default: ;
                endcase

                e_new.total_bytes  = btb;
                e_new.total_allocs = btc;
                e_new.live_bytes   = blb;
                e_new.live_allocs  = blc;

                if (upd_go)
                begin
                    if (eff_ovf)
                    begin
                        otb_next = btb;
                        otc_next = btc;
                        olb_next = blb;
                        olc_next = blc;
                    end
                    else if (op_reg == astc_pkg::OP_ALLOC ||
                             (op_reg == astc_pkg::OP_FREE && oc != astc_pkg::OC_SKIP))
                        ram_we = 1'b1;
                    if (oc == astc_pkg::OC_NEW)
                        used_next = used_reg + 13'd1;

                    ov_next     = 1'b1;
                    r_slot_next = eff_ovf ? astc_pkg::SLOT_OVF : 13'(idx_reg);
                    r_oc_next   = oc;
                    r_e_next    = e_new;
                    if (eff_ovf)
                    begin
                        r_e_next.valid   = 1'b0;
                        r_e_next.address = 64'd0;
                        r_e_next.line    = 32'd0;
                    end
                    r_used_next = (oc == astc_pkg::OC_NEW) ? used_reg + 13'd1 : used_reg;
                end
            end
            default: ;
        endcase
    end

    assign ram_wdata = ram_we ? e_new : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= astc_pkg::ST_CLEAR;
            clr_reg   <= '0;
            otb_reg   <= '0;
            otc_reg   <= '0;
            olb_reg   <= '0;
            olc_reg   <= '0;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            step_reg  <= '0;
            pass2_reg <= 1'b0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            otb_reg   <= otb_next;
            otc_reg   <= otc_next;
            olb_reg   <= olb_next;
            olc_reg   <= olc_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
            step_reg  <= step_next;
            pass2_reg <= pass2_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        line_reg   <= line_next;
        size_reg   <= size_next;
        h_reg      <= h_next;
        idx_reg    <= idx_next;
        r_slot_reg <= r_slot_next;
        r_oc_reg   <= r_oc_next;
        r_e_reg    <= r_e_next;
        r_used_reg <= r_used_next;
    end

    assign out_valid     = ov_reg;
    assign slot          = r_slot_reg;
    assign outcome       = r_oc_reg;
    assign entry_valid   = r_e_reg.valid;
    assign entry_address = r_e_reg.address;
    assign entry_line    = r_e_reg.line;
    assign total_bytes   = r_e_reg.total_bytes;
    assign total_allocs  = r_e_reg.total_allocs;
    assign live_bytes    = r_e_reg.live_bytes;
    assign live_allocs   = r_e_reg.live_allocs;
    assign sites_used    = r_used_reg;

endmodule

FILE: hdl/astc_checker.sv
// Port-level checker for the site statistics table, bound to the top level.
`timescale 1ns / 1ps
`include "alloc_site_stats_table_core_assert.svh"
module astc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [12:0] slot,
    input logic [2:0]  outcome,
    input logic        entry_valid,
    input logic [31:0] total_allocs,
    input logic [31:0] live_allocs
);

    logic ovf_word, site_word, ovf_ok, site_ok;

    assign ovf_word  = out_valid && outcome == astc_pkg::OC_OVF;
    assign site_word = out_valid && (outcome == astc_pkg::OC_HIT ||
                                     outcome == astc_pkg::OC_NEW);
    assign ovf_ok    = slot == astc_pkg::SLOT_OVF && !entry_valid;
    assign site_ok   = entry_valid && slot < astc_pkg::SLOT_OVF;

    `ASTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `ASTC_ASSERT_NOW(a_ovf_slot, ovf_word, ovf_ok)
    `ASTC_ASSERT_NOW(a_hit_valid, site_word, site_ok)
    `ASTC_ASSERT_NOW(a_live_le_total, out_valid, live_allocs <= total_allocs)

endmodule

bind alloc_site_stats_table_core astc_checker u_astc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .slot         (slot),
    .outcome      (outcome),
    .entry_valid  (entry_valid),
    .total_allocs (total_allocs),
    .live_allocs  (live_allocs)
);
